### hw/rtl/psa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_pkg
// Shared types and constants of the priority scheduler with aging.
// ----------------------------------------------------------------------------
package psa_pkg;

  localparam int READY_DEPTH  = 16;
  localparam int WORKER_COUNT = 8;
  localparam int RIDX_W       = $clog2(READY_DEPTH);
  localparam int RCNT_W       = $clog2(READY_DEPTH + 1);
  localparam int WIDX_W       = $clog2(WORKER_COUNT);

  localparam logic [2:0] ADDR_POLICY = 3'd0;
  localparam logic [2:0] ADDR_AGING  = 3'd4;

  typedef enum logic [1:0] {
    CMD_ENTER   = 2'd0,
    CMD_CONNECT = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_TICK    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_ASSIGN  = 2'd0,
    KIND_PREEMPT = 2'd1,
    KIND_AGED    = 2'd2,
    KIND_DROP    = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE, S_AGE_RD, S_AGE_EV, S_SCHED, S_SCAN_RD, S_SCAN_EV, S_PICK,
    S_AS_RD, S_AS_EV, S_SH_RD, S_SH_WR, S_DONE
  } state_t;

  typedef struct packed {
    logic [15:0] job;
    logic [7:0]  pri;
    logic [31:0] stamp;
  } ready_entry_t;

  typedef struct packed {
    kind_t             kind;
    logic [15:0]       job;
    logic [WIDX_W-1:0] worker;
    logic [7:0]        old_pri;
    logic [7:0]        new_pri;
  } result_t;

  typedef struct packed {
    logic              any_present;
    logic              idle_found;
    logic [WIDX_W-1:0] idle_slot;
    logic              victim_found;
    logic [WIDX_W-1:0] victim_slot;
    logic [15:0]       victim_job;
    logic [7:0]        victim_pri;
  } worker_status_t;

  typedef struct packed {
    logic              connect;
    logic              release_en;
    logic              assign_en;
    logic [WIDX_W-1:0] slot;
    logic [15:0]       job;
    logic [7:0]        pri;
  } worker_ctrl_t;

endpackage

### hw/rtl/psa_ready_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_ready_mem
// Ready table storage: one write port and one registered read port.
// ----------------------------------------------------------------------------
module psa_ready_mem
  import psa_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [RIDX_W-1:0] wr_addr,
  input  ready_entry_t      wr_data,
  input  logic [RIDX_W-1:0] rd_addr,
  output ready_entry_t      rd_data
);

  ready_entry_t mem [READY_DEPTH];
  ready_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/psa_workers.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_workers
// Worker table with idle and preemption victim selection.
// ----------------------------------------------------------------------------
module psa_workers
  import psa_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  worker_ctrl_t   ctrl,
  output worker_status_t status
);

  logic [WORKER_COUNT-1:0] present_r;
  logic [WORKER_COUNT-1:0] idle_r;
  logic [15:0]             job_r [WORKER_COUNT];
  logic [7:0]              pri_r [WORKER_COUNT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
      idle_r    <= '0;
    end else begin
      if (ctrl.connect && !present_r[ctrl.slot]) begin
        present_r[ctrl.slot] <= 1'b1;
        idle_r[ctrl.slot]    <= 1'b1;
      end
      if (ctrl.release_en && present_r[ctrl.slot]) begin
        idle_r[ctrl.slot] <= 1'b1;
      end
      if (ctrl.assign_en) begin
        idle_r[ctrl.slot] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.assign_en) begin
      job_r[ctrl.slot] <= ctrl.job;
      pri_r[ctrl.slot] <= ctrl.pri;
    end
  end

  always_comb begin
    status = '0;
    status.any_present = |present_r;
    for (int w = WORKER_COUNT - 1; w >= 0; w--) begin
      if (present_r[w] && idle_r[w]) begin
        status.idle_found = 1'b1;
        status.idle_slot  = WIDX_W'(w);
      end
    end
    for (int w = 0; w < WORKER_COUNT; w++) begin
      if (present_r[w] && !idle_r[w]) begin
        if (!status.victim_found || pri_r[w] > status.victim_pri) begin
          status.victim_found = 1'b1;
          status.victim_slot  = WIDX_W'(w);
          status.victim_pri   = pri_r[w];
          status.victim_job   = job_r[w];
        end
      end
    end
  end

endmodule

### hw/rtl/psa_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_cfg
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
module psa_cfg
  import psa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic        policy,
  output logic [19:0] aging_time
);

  logic        policy_r;
  logic [19:0] aging_r;
  logic        wr;

  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= 1'b0;
      aging_r  <= 20'd1000;
    end else if (wr) begin
      if (paddr[2] == ADDR_AGING[2]) begin
        aging_r <= pwdata[19:0];
      end else begin
        policy_r <= pwdata[0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == ADDR_AGING[2]) begin
      prdata = {12'd0, aging_r};
    end else begin
      prdata = {31'd0, policy_r};
    end
  end

  assign pready     = 1'b1;
  assign policy     = policy_r;
  assign aging_time = aging_r;

endmodule

### hw/rtl/priority_scheduler_with_aging_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_scheduler_with_aging_unit
// Job dispatcher with a ready table in memory, a worker table and aging.
// ----------------------------------------------------------------------------
// An event is taken when start is high and busy is low; busy then stays high
// until every result of the event has been presented. Results appear at most
// one per cycle on out_valid and cannot be held off; out_last marks the final
// one. The ready table sits in a memory with one registered read port, so
// every table entry visited takes a read state and then a state that uses
// the data. An aging tick in priority mode walks every ready entry, the
// priority search visits every ready entry, and an assignment moves up each
// entry behind the assigned one.
// ----------------------------------------------------------------------------
module priority_scheduler_with_aging_unit
  import psa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_job_id,
  input  logic [7:0]  in_job_priority,
  input  logic [2:0]  in_worker_slot,
  input  logic [31:0] in_time_ms,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [15:0] out_job_id,
  output logic [2:0]  out_worker,
  output logic [7:0]  out_old_priority,
  output logic [7:0]  out_new_priority,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  state_t            state_r, state_nxt;
  logic [RCNT_W-1:0] count_r, count_nxt;
  logic [RCNT_W-1:0] idx_r, idx_nxt;
  logic [RIDX_W-1:0] best_idx_r, best_idx_nxt;
  logic [7:0]        best_pri_r, best_pri_nxt;
  logic [31:0]       now_r, now_nxt;
  logic              pend_vld_r, pend_vld_nxt;
  result_t           pend_r, pend_nxt;

  logic              policy;
  logic [19:0]       aging_time;
  worker_ctrl_t      wctrl;
  worker_status_t    wstat;
  logic              wr_en;
  logic [RIDX_W-1:0] wr_addr;
  ready_entry_t      wr_data;
  logic [RCNT_W-1:0] rd_idx;
  ready_entry_t      rd_data;
  logic              emit_en;
  result_t           emit_res;
  logic [31:0]       wait_ms;
  logic [RCNT_W-1:0] idx_inc;

  psa_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .policy     (policy),
    .aging_time (aging_time)
  );

  psa_workers u_workers (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (wctrl),
    .status (wstat)
  );

  psa_ready_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_idx[RIDX_W-1:0]),
    .rd_data (rd_data)
  );

  assign wait_ms = now_r - rd_data.stamp;
  assign idx_inc = idx_r + RCNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      pend_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_pri_r <= best_pri_nxt;
    now_r      <= now_nxt;
    pend_r     <= pend_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    best_idx_nxt = best_idx_r;
    best_pri_nxt = best_pri_r;
    now_nxt      = now_r;
    wctrl        = '0;
    wr_en        = 1'b0;
    wr_addr      = idx_r[RIDX_W-1:0];
    wr_data      = rd_data;
    rd_idx       = idx_r;
    emit_en      = 1'b0;
    emit_res     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          now_nxt   = in_time_ms;
          state_nxt = S_SCHED;
          unique case (cmd_t'(in_cmd))
            CMD_ENTER: begin
              if (count_r == RCNT_W'(READY_DEPTH)) begin
                emit_en          = 1'b1;
                emit_res.kind    = KIND_DROP;
                emit_res.job     = in_job_id;
                emit_res.old_pri = in_job_priority;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = count_r[RIDX_W-1:0];
                wr_data   = '{job: in_job_id, pri: in_job_priority, stamp: in_time_ms};
                count_nxt = count_r + RCNT_W'(1);
              end
            end
            CMD_CONNECT: begin
              wctrl.connect = 1'b1;
              wctrl.slot    = in_worker_slot;
            end
            CMD_RELEASE: begin
              wctrl.release_en = 1'b1;
              wctrl.slot       = in_worker_slot;
            end
            CMD_TICK: begin
              if (policy) begin
                idx_nxt   = '0;
                state_nxt = S_AGE_RD;
              end
            end
          endcase
        end
      end
      S_AGE_RD: begin
        state_nxt = (idx_r >= count_r) ? S_SCHED : S_AGE_EV;
      end
      S_AGE_EV: begin
        if (rd_data.pri > 8'd1 && wait_ms >= {12'd0, aging_time}) begin
          wr_en            = 1'b1;
          wr_data.pri      = rd_data.pri - 8'd1;
          wr_data.stamp    = now_r;
          emit_en          = 1'b1;
          emit_res.kind    = KIND_AGED;
          emit_res.job     = rd_data.job;
          emit_res.old_pri = rd_data.pri;
          emit_res.new_pri = rd_data.pri - 8'd1;
        end
        idx_nxt   = idx_inc;
        state_nxt = S_AGE_RD;
      end
      S_SCHED: begin
        idx_nxt = '0;
        if (count_r == '0) begin
          state_nxt = S_DONE;
        end else if (!policy) begin
          state_nxt = wstat.idle_found ? S_AS_RD : S_DONE;
        end else begin
          state_nxt = wstat.any_present ? S_SCAN_RD : S_DONE;
        end
      end
      S_SCAN_RD: begin
        state_nxt = (idx_r >= count_r) ? S_PICK : S_SCAN_EV;
      end
      S_SCAN_EV: begin
        if (idx_r == '0 || rd_data.pri < best_pri_r) begin
          best_pri_nxt = rd_data.pri;
          best_idx_nxt = idx_r[RIDX_W-1:0];
        end
        idx_nxt   = idx_inc;
        state_nxt = S_SCAN_RD;
      end
      S_PICK: begin
        state_nxt = S_DONE;
        if (wstat.idle_found) begin
          idx_nxt   = {1'b0, best_idx_r};
          state_nxt = S_AS_RD;
        end else if (wstat.victim_found && best_pri_r < wstat.victim_pri) begin
          emit_en          = 1'b1;
          emit_res.kind    = KIND_PREEMPT;
          emit_res.job     = wstat.victim_job;
          emit_res.worker  = wstat.victim_slot;
          emit_res.old_pri = wstat.victim_pri;
        end
      end
      S_AS_RD: begin
        state_nxt = S_AS_EV;
      end
      S_AS_EV: begin
        emit_en          = 1'b1;
        emit_res.kind    = KIND_ASSIGN;
        emit_res.job     = rd_data.job;
        emit_res.worker  = wstat.idle_slot;
        emit_res.old_pri = rd_data.pri;
        wctrl.assign_en  = 1'b1;
        wctrl.slot       = wstat.idle_slot;
        wctrl.job        = rd_data.job;
        wctrl.pri        = rd_data.pri;
        state_nxt        = S_SH_RD;
      end
      S_SH_RD: begin
        rd_idx = idx_inc;
        if (idx_inc >= count_r) begin
          count_nxt = count_r - RCNT_W'(1);
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SH_WR;
        end
      end
      S_SH_WR: begin
        wr_en     = 1'b1;
        idx_nxt   = idx_inc;
        state_nxt = S_SH_RD;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    out_valid    = 1'b0;
    out_last     = 1'b0;
    if (emit_en) begin
      out_valid    = pend_vld_r;
      pend_vld_nxt = 1'b1;
      pend_nxt     = emit_res;
    end else if (state_r == S_DONE) begin
      out_valid    = pend_vld_r;
      out_last     = 1'b1;
      pend_vld_nxt = 1'b0;
    end
  end

  assign busy             = (state_r != S_IDLE);
  assign out_kind         = pend_r.kind;
  assign out_job_id       = pend_r.job;
  assign out_worker       = pend_r.worker;
  assign out_old_priority = pend_r.old_pri;
  assign out_new_priority = pend_r.new_pri;

endmodule
